/* rtl/core/bsm_pkg.sv */
// Shared types and constants for the block sparse matrix-vector multiplier.
`default_nettype none

package bsm_pkg;

   localparam int unsigned MaxBlockCols = 1024;
   localparam int unsigned BlockSize    = 5;
   localparam int unsigned DataW        = 32;
   localparam int unsigned AccW         = 48;
   localparam int unsigned ProdW        = 64;
   localparam int unsigned RowW         = 10;
   localparam int unsigned FracW        = 16;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_COLUMN  = 2'd1,
      REQ_ROW_END = 2'd2
   } req_kind_type;

   typedef logic signed [DataW-1:0] data_type;
   typedef logic [RowW-1:0]         row_type;

   // Per-lane control: advance moves the multiply stage, add/emit qualify the
   // accumulate stage.
   typedef struct packed {
      logic advance;
      logic add;
      logic emit;
   } lane_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/bsm_ifs.sv */
// Request and response channel interfaces of the block sparse matrix-vector multiplier.
`default_nettype none

interface bsm_req_if import bsm_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [12:0] x_index;
   data_type    x_value;
   logic [9:0]  block_col;
   logic [2:0]  sub_col;
   data_type    m0;
   data_type    m1;
   data_type    m2;
   data_type    m3;
   data_type    m4;
   logic        row_end;

   modport source (
      output valid, req_type, x_index, x_value, block_col, sub_col,
             m0, m1, m2, m3, m4, row_end,
      input  ready
   );
   modport sink (
      input  valid, req_type, x_index, x_value, block_col, sub_col,
             m0, m1, m2, m3, m4, row_end,
      output ready
   );
endinterface

interface bsm_rsp_if import bsm_pkg::*; ();
   logic     valid;
   logic     ready;
   row_type  row_index;
   data_type v0;
   data_type v1;
   data_type v2;
   data_type v3;
   data_type v4;

   modport source (
      output valid, row_index, v0, v1, v2, v3, v4,
      input  ready
   );
   modport sink (
      input  valid, row_index, v0, v1, v2, v3, v4,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/bsm_mac_lane.sv */
// One row lane: registered Q16.16 multiply, then saturating 48-bit accumulate.
`default_nettype none

module bsm_mac_lane import bsm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lane_ctl_type ctl,
   input  wire data_type     mul_x,
   input  wire data_type     mul_m,
   output      data_type     sum_sat
);

   localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
   localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
   localparam data_type OutMax = {1'b0, {(DataW-1){1'b1}}};
   localparam data_type OutMin = {1'b1, {(DataW-1){1'b0}}};

   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [AccW-1:0]  term;
   logic signed [AccW:0]    sum;
   logic signed [AccW-1:0]  acc_sat;

   assign prod_in = ProdW'(mul_x) * ProdW'(mul_m);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff <= prod_in;
      end
   end

   // arithmetic shift is floor division by 2^16
   assign term = ctl.add ? AccW'(prod_ff >>> FracW) : '0;
   assign sum  = (AccW+1)'(acc_ff) + (AccW+1)'(term);

   always_comb begin
      if (sum[AccW] != sum[AccW-1]) begin
         acc_sat = sum[AccW] ? AccMin : AccMax;
      end else begin
         acc_sat = sum[AccW-1:0];
      end
      // 32-bit clamp taken straight from the unsaturated sum
      if ((&sum[AccW:DataW-1]) || !(|sum[AccW:DataW-1])) begin
         sum_sat = sum[DataW-1:0];
      end else begin
         sum_sat = sum[AccW] ? OutMin : OutMax;
      end
   end

   assign acc_in = ctl.emit ? '0 : acc_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.advance) begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/block_sparse_matvec_5x5.sv */
// Block compressed row sparse matrix-vector multiply, 5x5 blocks, Q16.16.
//
// req_if carries three kinds of transaction: vector writes load x[x_index] into
// an on-chip vector store, column transactions give one column of a 5x5 block
// and are multiplied by x[5*block_col+sub_col] into five row accumulators, and
// empty-row transactions close a block row. A column with row_end, or an
// empty-row transaction, produces one rsp_if transaction: the block row number
// and the five sums saturated to 32 bits, after which the accumulators clear.
// Vector writes and columns without row_end produce nothing.
//
// Throughput is one transaction per cycle while req_if.ready is high. A result
// reaches rsp_if after its closing request is accepted: the store is read on
// the accepting edge, then multiply, then accumulate into the output register.
// A store write is visible to a column accepted in the next cycle.
//
// Reset clears the accumulators, the row counter and the pipeline; the vector
// store is not cleared and must be written before it is read. When rsp_if is
// stalled, requests keep flowing until a row-closing transaction reaches the
// accumulate stage while the output register is still full; req_if.ready then
// drops until the pending result is taken.
`default_nettype none

module block_sparse_matvec_5x5 import bsm_pkg::*; #(
   parameter int unsigned MAX_BLOCK_COLS = MaxBlockCols
) (
   input wire logic  clock,
   input wire logic  reset,
   bsm_req_if.sink   req_if,
   bsm_rsp_if.source rsp_if
);

   localparam int unsigned Depth = MAX_BLOCK_COLS * BlockSize;
   localparam int unsigned AddrW = $clog2(Depth);
   localparam int unsigned IdxW  = (AddrW > 14) ? AddrW : 14;

   req_kind_type kind;
   logic         accept;
   logic         advance;
   logic         wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [AddrW-1:0] rd_addr;
   logic [IdxW-1:0]  col_idx;
   logic         col_ok;
   logic         s1_add_in, s1_emit_in;
   logic         s1_add_ff, s1_emit_ff;
   logic         s2_add_ff, s2_emit_ff;
   data_type     m_in [BlockSize];
   data_type     m_s1_ff [BlockSize];
   data_type     x_rd_ff;
   data_type     vec_mem [Depth];
   data_type     lane_out [BlockSize];
   data_type     v_ff [BlockSize];
   logic         rsp_valid_ff;
   row_type      rsp_row_ff;
   row_type      row_cnt_ff;
   lane_ctl_type lane_ctl;

   assign kind    = req_kind_type'(req_if.req_type);
   assign advance = !(s2_emit_ff && rsp_valid_ff && !rsp_if.ready);
   assign req_if.ready = advance;
   assign accept  = req_if.valid && req_if.ready;

   assign m_in[0] = req_if.m0;
   assign m_in[1] = req_if.m1;
   assign m_in[2] = req_if.m2;
   assign m_in[3] = req_if.m3;
   assign m_in[4] = req_if.m4;

   // 5*block_col + sub_col
   assign col_idx = (IdxW'(req_if.block_col) << 2) + IdxW'(req_if.block_col)
                  + IdxW'(req_if.sub_col);
   assign rd_addr = col_idx[AddrW-1:0];
   assign col_ok  = (32'(req_if.block_col) < 32'(MAX_BLOCK_COLS))
                 && (req_if.sub_col < 3'(BlockSize));
   assign wr_addr = AddrW'(req_if.x_index);

   always_comb begin
      wr_en      = 1'b0;
      s1_add_in  = 1'b0;
      s1_emit_in = 1'b0;
      unique case (kind)
         REQ_WRITE: begin
            wr_en = accept && (32'(req_if.x_index) < 32'(Depth));
         end
         REQ_COLUMN: begin
            s1_add_in  = accept && col_ok;
            s1_emit_in = accept && req_if.row_end;
         end
         REQ_ROW_END: begin
            s1_emit_in = accept;
         end
         default: begin
         end
      endcase
   end

   // vector store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_mem[wr_addr] <= req_if.x_value;
      end
      if (advance) begin
         x_rd_ff <= vec_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < BlockSize; r++) begin
            m_s1_ff[r] <= m_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_add_ff  <= 1'b0;
         s1_emit_ff <= 1'b0;
         s2_add_ff  <= 1'b0;
         s2_emit_ff <= 1'b0;
      end else if (advance) begin
         s1_add_ff  <= s1_add_in;
         s1_emit_ff <= s1_emit_in;
         s2_add_ff  <= s1_add_ff;
         s2_emit_ff <= s1_emit_ff;
      end
   end

   assign lane_ctl = '{advance: advance, add: s2_add_ff, emit: s2_emit_ff};

   for (genvar r = 0; r < BlockSize; r++) begin : g_lane
      bsm_mac_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .mul_x   (x_rd_ff),
         .mul_m   (m_s1_ff[r]),
         .sum_sat (lane_out[r])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         row_cnt_ff   <= '0;
      end else if (advance && s2_emit_ff) begin
         rsp_valid_ff <= 1'b1;
         row_cnt_ff   <= row_cnt_ff + 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_emit_ff) begin
         rsp_row_ff <= row_cnt_ff;
         for (int r = 0; r < BlockSize; r++) begin
            v_ff[r] <= lane_out[r];
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.row_index = rsp_row_ff;
   assign rsp_if.v0        = v_ff[0];
   assign rsp_if.v1        = v_ff[1];
   assign rsp_if.v2        = v_ff[2];
   assign rsp_if.v3        = v_ff[3];
   assign rsp_if.v4        = v_ff[4];

   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      advance && s2_emit_ff |=> rsp_valid_ff && rsp_row_ff == $past(row_cnt_ff))
      else $error("row result not loaded into output register");

   a_row_count_steps: assert property (@(posedge clock) disable iff (reset)
      advance && s2_emit_ff |=> row_cnt_ff == RowW'($past(row_cnt_ff) + 1'b1))
      else $error("row counter did not step on emit");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_add_ff) && $stable(s1_emit_ff) && s2_emit_ff)
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

/* bench/block_sparse_matvec_5x5_tb.sv */
// Self-checking testbench for the 5x5 block sparse matrix-vector multiplier.
module block_sparse_matvec_5x5_tb;
   import bsm_pkg::*;

   localparam int unsigned StoreDepth = MaxBlockCols * BlockSize;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam longint AccHi = (longint'(1) <<< (AccW - 1)) - 1;
   localparam longint AccLo = -AccHi - 1;
   localparam longint OutHi = (longint'(1) <<< (DataW - 1)) - 1;
   localparam longint OutLo = -OutHi - 1;
   localparam data_type ONE = 32'sh0001_0000;
   localparam data_type QMAX = 32'sh7FFF_FFFF;
   localparam data_type QMIN = 32'sh8000_0000;
   localparam data_type LSB_NEG = 32'shFFFF_FFFF;
   localparam int RandomItems = 200;
   localparam int CalmItems = 60;
   localparam int WrapRows = 1030;
   localparam int HoldCycles = 250;
   localparam int CycleLimit = 400000;
   localparam int ReportMax = 10;

   typedef struct packed {
      logic [1:0]                         kind;
      logic [12:0]                        x_index;
      data_type                           x_value;
      logic [9:0]                         block_col;
      logic [2:0]                         sub_col;
      logic [BlockSize-1:0][DataW-1:0]    m;
      logic                               row_end;
   } matvec_req_type;

   typedef struct packed {
      row_type                            row;
      logic [BlockSize-1:0][DataW-1:0]    v;
   } row_sums_type;

   typedef struct packed {
      matvec_req_type item;
      logic           typed;
      row_sums_type   want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   bsm_req_if req_ch ();
   bsm_rsp_if rsp_ch ();

   block_sparse_matvec_5x5 uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #10 clock = ~clock;

   // predictor state
   data_type     x_mem [StoreDepth];
   bit           x_written [StoreDepth];
   int           written_idx [$];
   longint       acc [BlockSize];
   row_type      row_count;
   int           rows_done;
   row_sums_type pending_rows [$];

   dir_row_type  dir_tab [$];
   int           n_errors;
   int           n_items;
   int           cycle_count;
   bit           src_gaps;
   bit           sink_gaps;
   bit           sink_hold;
   bit           calm;

   function automatic longint saturate(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic row_sums_type close_block_row();
      row_sums_type res;
      res.row = row_count;
      for (int r = 0; r < BlockSize; r++) begin
         res.v[r] = 32'(saturate(acc[r], OutLo, OutHi));
         acc[r] = 0;
      end
      row_count++;
      rows_done++;
      return res;
   endfunction

   // Returns 1 when the transaction closes a block row.
   function automatic bit predict_matvec(input matvec_req_type it,
                                         output row_sums_type res);
      longint xv;
      longint prod;
      int idx;
      res = '0;
      case (it.kind)
         REQ_WRITE: begin
            if (it.x_index < StoreDepth) begin
               x_mem[it.x_index] = it.x_value;
               if (!x_written[it.x_index]) begin
                  x_written[it.x_index] = 1'b1;
                  written_idx.push_back(int'(it.x_index));
               end
            end
            return 1'b0;
         end
         REQ_ROW_END: begin
            res = close_block_row();
            return 1'b1;
         end
         REQ_COLUMN: begin
            // block_col is 10 bits wide, so only sub_col can fall out of range
            if (it.sub_col < BlockSize) begin
               idx = int'(it.block_col) * BlockSize + int'(it.sub_col);
               xv = longint'(x_mem[idx]);
               for (int r = 0; r < BlockSize; r++) begin
                  // arithmetic shift of the exact product floors toward minus infinity
                  prod = (longint'(signed'(it.m[r])) * xv) >>> FracW;
                  acc[r] = saturate(acc[r] + prod, AccLo, AccHi);
               end
            end
            if (it.row_end) begin
               res = close_block_row();
               return 1'b1;
            end
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void flag_error(string msg);
      n_errors++;
      if (n_errors <= ReportMax) $display("ERROR: %s", msg);
   endfunction

   function automatic void check_row(row_sums_type got);
      row_sums_type want;
      bit bad;
      if (pending_rows.size() == 0) begin
         flag_error($sformatf("unexpected result: row %0d v %h %h %h %h %h", got.row,
            got.v[0], got.v[1], got.v[2], got.v[3], got.v[4]));
         return;
      end
      want = pending_rows.pop_front();
      bad = (got.row !== want.row);
      for (int r = 0; r < BlockSize; r++)
         if (got.v[r] !== want.v[r]) bad = 1'b1;
      if (bad)
         flag_error($sformatf(
            "expected row %0d v %h %h %h %h %h, got row %0d v %h %h %h %h %h",
            want.row, want.v[0], want.v[1], want.v[2], want.v[3], want.v[4],
            got.row, got.v[0], got.v[1], got.v[2], got.v[3], got.v[4]));
   endfunction

   // Fields a transaction kind does not use carry random values.
   function automatic matvec_req_type junk_item(logic [1:0] kind);
      matvec_req_type it;
      it.kind = kind;
      it.x_index = 13'($urandom);
      it.x_value = $urandom;
      it.block_col = 10'($urandom);
      it.sub_col = 3'($urandom);
      for (int r = 0; r < BlockSize; r++) it.m[r] = $urandom;
      it.row_end = 1'($urandom);
      return it;
   endfunction

   function automatic matvec_req_type write_item(int idx, data_type val);
      matvec_req_type it;
      it = junk_item(REQ_WRITE);
      it.x_index = 13'(idx);
      it.x_value = val;
      return it;
   endfunction

   function automatic matvec_req_type column_item(int bc, int sc, data_type a, data_type b,
                                                  data_type c, data_type d, data_type e,
                                                  bit re);
      matvec_req_type it;
      it = junk_item(REQ_COLUMN);
      it.block_col = 10'(bc);
      it.sub_col = 3'(sc);
      it.m[0] = a;
      it.m[1] = b;
      it.m[2] = c;
      it.m[3] = d;
      it.m[4] = e;
      it.row_end = re;
      return it;
   endfunction

   function automatic row_sums_type sums(int row, data_type a, data_type b, data_type c,
                                         data_type d, data_type e);
      row_sums_type res;
      res.row = row_type'(row);
      res.v[0] = a;
      res.v[1] = b;
      res.v[2] = c;
      res.v[3] = d;
      res.v[4] = e;
      return res;
   endfunction

   function automatic void plan_item(matvec_req_type it);
      dir_row_type row;
      row.item = it;
      row.typed = 1'b0;
      row.want = '0;
      dir_tab.push_back(row);
   endfunction

   function automatic void plan_checked(matvec_req_type it, row_sums_type want);
      dir_row_type row;
      row.item = it;
      row.typed = 1'b1;
      row.want = want;
      dir_tab.push_back(row);
   endfunction

   function automatic data_type pick_value();
      case ($urandom_range(0, 4))
         0: return data_type'($urandom_range(0, 1 << 20)) - (1 << 19);
         1: return data_type'($urandom_range(0, 1 << 26)) - (1 << 25);
         2: begin
            case ($urandom_range(0, 4))
               0: return QMAX;
               1: return QMIN;
               2: return '0;
               3: return LSB_NEG;
               default: return ONE;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Called right after the edge that accepted the previous transaction.
   task automatic send_item(input dir_row_type row);
      matvec_req_type it;
      row_sums_type res;
      bit hit;
      it = row.item;
      if (src_gaps && !calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= it.kind;
      req_ch.x_index   <= it.x_index;
      req_ch.x_value   <= it.x_value;
      req_ch.block_col <= it.block_col;
      req_ch.sub_col   <= it.sub_col;
      req_ch.m0        <= it.m[0];
      req_ch.m1        <= it.m[1];
      req_ch.m2        <= it.m[2];
      req_ch.m3        <= it.m[3];
      req_ch.m4        <= it.m[4];
      req_ch.row_end   <= it.row_end;
      // ready is settled at the falling edge; the transaction lands on the next rise
      do begin
         @(negedge clock);
         hit = (req_ch.ready === 1'b1);
         @(posedge clock);
      end while (!hit);
      n_items++;
      if (predict_matvec(it, res))
         pending_rows.push_back(row.typed ? row.want : res);
   endtask

   task automatic send_plain(input matvec_req_type it);
      dir_row_type row;
      row.item = it;
      row.typed = 1'b0;
      row.want = '0;
      send_item(row);
   endtask

   task automatic send_random_write();
      int idx;
      if ($urandom_range(0, 7) == 0) idx = $urandom_range(StoreDepth, 8191);
      else idx = $urandom_range(0, StoreDepth - 1);
      send_plain(write_item(idx, pick_value()));
   endtask

   // A block row of 1 to 6 columns over written entries, closed by row_end or
   // by an empty-row transaction; now and then a write or a dead column slips in.
   task automatic send_random_row();
      int ncol;
      int idx;
      bit close_empty;
      ncol = $urandom_range(1, 6);
      close_empty = ($urandom_range(0, 5) == 0);
      if (written_idx.size() == 0) send_random_write();
      for (int c = 0; c < ncol; c++) begin
         if ($urandom_range(0, 5) == 0) send_random_write();
         if (written_idx.size() == 0) send_random_write();
         if ($urandom_range(0, 9) == 0) begin
            send_plain(column_item($urandom_range(0, 1023), $urandom_range(5, 7),
               pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
               (c == ncol - 1) && !close_empty));
         end else begin
            idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
            send_plain(column_item(idx / BlockSize, idx % BlockSize,
               pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
               (c == ncol - 1) && !close_empty));
         end
      end
      if (close_empty) send_plain(junk_item(REQ_ROW_END));
   endtask

   // stimulus
   initial begin
      int base;
      matvec_req_type odd;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_WRITE;
      req_ch.x_index = '0;
      req_ch.x_value = '0;
      req_ch.block_col = '0;
      req_ch.sub_col = '0;
      req_ch.m0 = '0;
      req_ch.m1 = '0;
      req_ch.m2 = '0;
      req_ch.m3 = '0;
      req_ch.m4 = '0;
      req_ch.row_end = 1'b0;
      src_gaps = 1'b1;
      calm = 1'b0;
      for (int r = 0; r < BlockSize; r++) acc[r] = 0;
      row_count = '0;

      plan_item(write_item(0, ONE));
      plan_item(write_item(1, QMAX));
      plan_item(write_item(StoreDepth - 1, QMIN));
      plan_item(write_item(StoreDepth - 2, LSB_NEG));
      plan_item(write_item(13'h1FFF, 32'sh1234_5678));   // beyond the store: dropped
      plan_item(write_item(StoreDepth, QMAX));           // first index past the store
      plan_checked(junk_item(REQ_ROW_END), sums(0, 0, 0, 0, 0, 0));
      // x = 1.0 passes the entries through unchanged
      plan_checked(column_item(0, 0, ONE, -ONE, QMAX, QMIN, 0, 1'b1),
         sums(1, ONE, -ONE, QMAX, QMIN, 0));
      // max times max, three times: accumulators pin at the 48-bit limit
      plan_item(column_item(0, 1, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0));
      plan_item(column_item(0, 1, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0));
      plan_checked(column_item(0, 1, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b1),
         sums(2, QMAX, QMAX, QMAX, QMAX, QMAX));
      // last block column, x = min: swings positive, then hard negative
      plan_item(column_item(1023, 4, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0));
      plan_item(column_item(1023, 4, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0));
      plan_item(column_item(1023, 4, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0));
      plan_checked(column_item(1023, 4, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b1),
         sums(3, QMIN, QMIN, QMIN, QMIN, QMIN));
      // x = -2^-16: products round toward minus infinity
      plan_checked(column_item(1023, 3, 1, -1, ONE, 2, QMAX, 1'b1),
         sums(4, LSB_NEG, 0, LSB_NEG, LSB_NEG, 32'shFFFF_8000));
      // dead sub-columns add nothing, row_end still closes the row
      plan_item(column_item(0, 5, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0));
      plan_checked(column_item(0, 7, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b1),
         sums(5, 0, 0, 0, 0, 0));
      odd = junk_item(REQ_UNKNOWN);
      odd.row_end = 1'b1;
      plan_item(odd);
      plan_item(column_item(0, 0, 2 * ONE, -3 * ONE, 5, -7, QMIN, 1'b0));
      plan_checked(junk_item(REQ_ROW_END), sums(6, 2 * ONE, -3 * ONE, 5, -7, QMIN));
      plan_item(column_item(0, 1, pick_value(), pick_value(), pick_value(), pick_value(),
         pick_value(), 1'b0));
      plan_item(column_item(0, 6, QMAX, QMIN, QMAX, QMIN, QMAX, 1'b1));
      plan_item(write_item(2, pick_value()));
      plan_item(column_item(0, 2, pick_value(), pick_value(), pick_value(), pick_value(),
         pick_value(), 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_item(dir_tab[i]);

      // run the row number past its wrap point
      while (rows_done < WrapRows) send_plain(junk_item(REQ_ROW_END));

      base = n_items;
      while (n_items < base + RandomItems) begin
         calm = (n_items >= base + RandomItems - CalmItems);
         if ($urandom_range(0, 15) == 0) src_gaps = !src_gaps;
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 8)) send_random_write();
            2, 3, 4, 5, 6: send_random_row();
            7: send_plain(junk_item(REQ_ROW_END));
            8: begin
               send_plain(junk_item(REQ_UNKNOWN));
               n_items--;   // ignored by the block
            end
            default: send_plain(column_item($urandom_range(0, 1023), $urandom_range(5, 7),
               pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
               1'($urandom)));
         endcase
      end
      req_ch.valid <= 1'b0;

      while (pending_rows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side ready, with random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      sink_gaps = 1'b1;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0)
            stall_left--;
         else if (sink_gaps && !calm && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 6);
         if ($urandom_range(0, 299) == 0) sink_gaps = !sink_gaps;
         rsp_ch.ready <= !sink_hold && stall_left == 0;
      end
   end

   // long hold-off on the result side so the pipeline backs up into req_if
   initial begin
      sink_hold = 1'b0;
      wait (rows_done >= 300);
      @(negedge clock);
      sink_hold = 1'b1;
      repeat (HoldCycles) @(negedge clock);
      sink_hold = 1'b0;
   end

   // result monitor: sampled at the falling edge, transaction lands on the next rise
   initial begin
      row_sums_type got;
      forever begin
         @(negedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.row = rsp_ch.row_index;
            got.v[0] = rsp_ch.v0;
            got.v[1] = rsp_ch.v1;
            got.v[2] = rsp_ch.v2;
            got.v[3] = rsp_ch.v3;
            got.v[4] = rsp_ch.v4;
            check_row(got);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) @(posedge clock) cycle_count++;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
